@@ rtl/lsw_pkg.sv @@
// Shared types, constants and helpers for the Laplacian sharpen window filter.
package lsw_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_MASK   = 7;
	localparam int MAX_HEIGHT = 4096;
	localparam int LS_ROWS    = MAX_MASK - 1;

	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int SLOT_W   = $clog2(LS_ROWS);
	localparam int MASK_W   = $clog2(MAX_MASK + 1);
	localparam int RSUM_W   = 8 + $clog2(MAX_MASK);
	localparam int TOT_W    = 8 + $clog2(MAX_MASK * MAX_MASK);
	localparam int SQ_W     = 2 * MASK_W;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	typedef logic [7:0] pix_t;
	typedef pix_t [LS_ROWS-1:0]  line_t;
	typedef pix_t [MAX_MASK-1:0] wcol_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_MASK   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] pixel_in;
		logic       frame_start;
	} in_t;

	typedef struct packed {
		logic [7:0]  sharpened;
		logic [11:0] center_row;
		logic [9:0]  center_col;
		logic        frame_end;
	} out_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} lb_ctl_t;

	typedef struct packed {
		logic shift;
		logic sum;
	} win_ctl_t;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(LS_ROWS - 1)) ? '0 : s + 1'b1;
	endfunction

endpackage

@@ rtl/laplacian_sharpen_window_filter_top.sv @@
// Top level: configuration, raster position, pipeline control and output register.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  input     | in_valid / in_stall  | in_data  (pixel_in, frame_start)
//  output    | out_valid / out_stall| out_data (sharpened, center_row, center_col,
//            |                      |           frame_end)
//  config    | cfg_we               | cfg_index, cfg_data
//
// One pixel per cycle sustained while out_stall does not hold the pipeline; the line store's
// single column read and write port sets it. A result is valid at the output after the accept
// edge does position and line-store read, then window shift, row sums, final sum and clamp.
// Reset clears position counters and pipeline valids; the line store is not cleared.
// Each stage holds when the one after it is full and held, so bubbles are squeezed out.
module laplacian_sharpen_window_filter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  lsw_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output lsw_pkg::out_t                  out_data,
	input  logic                           cfg_we,
	input  logic [lsw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsw_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [lsw_pkg::WIDTH_W-1:0]  width_q, w_eff;
	logic [lsw_pkg::HEIGHT_W-1:0] height_q, h_eff;
	logic [lsw_pkg::MASK_W-1:0]   mask_q, n_eff, nm1;

	logic [lsw_pkg::ROW_W-1:0]  row_q, row_d, pos_r;
	logic [lsw_pkg::COL_W-1:0]  col_q, col_d, pos_c;
	logic [lsw_pkg::SLOT_W-1:0] slot_q, slot_d, pos_s;
	logic [lsw_pkg::HEIGHT_W-1:0] r_a, r_n;
	logic [lsw_pkg::WIDTH_W-1:0]  c_a, c_n;
	logic [lsw_pkg::SLOT_W-1:0]   s_a;
	logic prod, fe;
	logic [11:0] crow;
	logic [9:0]  ccol;

	logic accept, en_s1, en_s2, en_s3, en_out;
	logic vld_s1, vld_s2, vld_s3, out_vld_q;
	lsw_pkg::pix_t pix_s1;
	logic [lsw_pkg::SLOT_W-1:0] slot_s1;
	logic [lsw_pkg::COL_W-1:0]  col_s1;
	logic prod_s1, fe_s1, fe_s2, fe_s3;
	logic [11:0] crow_s1, crow_s2, crow_s3;
	logic [9:0]  ccol_s1, ccol_s2, ccol_s3;
	lsw_pkg::out_t out_q;

	lsw_pkg::lb_ctl_t  lb_ctl;
	lsw_pkg::win_ctl_t win_ctl;
	lsw_pkg::line_t    lines;
	logic [7:0]        sharp;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lsw_pkg::WIDTH_W'(1024);
			height_q <= lsw_pkg::HEIGHT_W'(768);
			mask_q   <= lsw_pkg::MASK_W'(3);
		end else if (cfg_we) begin
			unique case (lsw_pkg::cfg_idx_t'(cfg_index))
				lsw_pkg::CFG_WIDTH:  width_q  <= cfg_data[lsw_pkg::WIDTH_W-1:0];
				lsw_pkg::CFG_HEIGHT: height_q <= cfg_data[lsw_pkg::HEIGHT_W-1:0];
				lsw_pkg::CFG_MASK:   mask_q   <= cfg_data[lsw_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_eff = (width_q == '0) ? lsw_pkg::WIDTH_W'(1) :
			(width_q > lsw_pkg::WIDTH_W'(lsw_pkg::MAX_WIDTH)) ?
			lsw_pkg::WIDTH_W'(lsw_pkg::MAX_WIDTH) : width_q;
		h_eff = (height_q == '0) ? lsw_pkg::HEIGHT_W'(1) :
			(height_q > lsw_pkg::HEIGHT_W'(lsw_pkg::MAX_HEIGHT)) ?
			lsw_pkg::HEIGHT_W'(lsw_pkg::MAX_HEIGHT) : height_q;
		n_eff = (mask_q == '0) ? lsw_pkg::MASK_W'(1) :
			(mask_q > lsw_pkg::MASK_W'(lsw_pkg::MAX_MASK)) ?
			lsw_pkg::MASK_W'(lsw_pkg::MAX_MASK) : mask_q;
		nm1 = n_eff - 1'b1;
	end

	// raster position of the incoming pixel and of the next one
	always_comb begin
		r_a = in_data.frame_start ? '0 : {1'b0, row_q};
		c_a = in_data.frame_start ? '0 : {1'b0, col_q};
		s_a = in_data.frame_start ? '0 : slot_q;
		if (c_a >= w_eff) begin
			c_a = '0;
			r_a = r_a + 1'b1;
			s_a = lsw_pkg::slot_inc(s_a);
		end
		if (r_a >= h_eff) begin
			r_a = '0;
			s_a = '0;
		end
		pos_r = r_a[lsw_pkg::ROW_W-1:0];
		pos_c = c_a[lsw_pkg::COL_W-1:0];
		pos_s = s_a;

		c_n    = {1'b0, pos_c} + 1'b1;
		r_n    = {1'b0, pos_r};
		slot_d = pos_s;
		if (c_n >= w_eff) begin
			c_n    = '0;
			r_n    = r_n + 1'b1;
			slot_d = lsw_pkg::slot_inc(pos_s);
			if (r_n >= h_eff) begin
				r_n    = '0;
				slot_d = '0;
			end
		end
		col_d = c_n[lsw_pkg::COL_W-1:0];
		row_d = r_n[lsw_pkg::ROW_W-1:0];

		prod = (pos_r >= lsw_pkg::ROW_W'(nm1)) && (pos_c >= lsw_pkg::COL_W'(nm1));
		crow = pos_r - 12'(nm1) + 12'(n_eff >> 1);
		ccol = pos_c - 10'(nm1) + 10'(n_eff >> 1);
		fe   = ({1'b0, pos_r} == h_eff - 1'b1) && ({1'b0, pos_c} == w_eff - 1'b1);
	end

	// stage enables
	assign en_out   = !out_vld_q || !out_stall;
	assign en_s3    = !vld_s3 || en_out;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_stall = !en_s1;
	assign accept   = in_valid && en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			slot_q    <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				row_q  <= row_d;
				col_q  <= col_d;
				slot_q <= slot_d;
			end
			if (en_s1) vld_s1 <= in_valid;
			// border pixels still update the store and window but drop out here
			if (en_s2) vld_s2 <= vld_s1 && prod_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_out) out_vld_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= in_data.pixel_in;
			slot_s1 <= pos_s;
			col_s1  <= pos_c;
			prod_s1 <= prod;
			crow_s1 <= crow;
			ccol_s1 <= ccol;
			fe_s1   <= fe;
		end
		if (en_s2) begin
			crow_s2 <= crow_s1;
			ccol_s2 <= ccol_s1;
			fe_s2   <= fe_s1;
		end
		if (en_s3) begin
			crow_s3 <= crow_s2;
			ccol_s3 <= ccol_s2;
			fe_s3   <= fe_s2;
		end
		if (en_out && vld_s3) begin
			out_q.sharpened  <= sharp;
			out_q.center_row <= crow_s3;
			out_q.center_col <= ccol_s3;
			out_q.frame_end  <= fe_s3;
		end
	end

	assign lb_ctl.rd     = accept;
	assign lb_ctl.wr     = vld_s1 && en_s2;
	assign win_ctl.shift = vld_s1 && en_s2;
	assign win_ctl.sum   = vld_s2 && en_s3;

	lsw_linebuf u_linebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (lb_ctl),
		.rd_col  (pos_c),
		.wr_col  (col_s1),
		.wr_slot (slot_s1),
		.wr_pix  (pix_s1),
		.rows    (lines)
	);

	lsw_window u_window (
		.clk   (clk),
		.ctl   (win_ctl),
		.pix   (pix_s1),
		.slot  (slot_s1),
		.lines (lines),
		.n     (n_eff),
		.sharp (sharp)
	);

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= lsw_pkg::SLOT_W'(lsw_pkg::LS_ROWS - 1))
		else $error("line slot out of range");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> vld_s1)
		else $error("accepted request lost before stage 1");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !en_s3 |=> vld_s3 && $stable(crow_s3))
		else $error("stage 3 request dropped while blocked");

	a_store_write_order: assert property (@(posedge clk) disable iff (!arst_n)
		lb_ctl.wr |-> win_ctl.shift)
		else $error("line store write without window shift");

endmodule

@@ rtl/lsw_linebuf.sv @@
// Line store: one entry per column holding all buffered rows, read-modify-write with forwarding.
module lsw_linebuf (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lsw_pkg::lb_ctl_t         ctl,
	input  logic [lsw_pkg::COL_W-1:0]  rd_col,
	input  logic [lsw_pkg::COL_W-1:0]  wr_col,
	input  logic [lsw_pkg::SLOT_W-1:0] wr_slot,
	input  lsw_pkg::pix_t            wr_pix,
	output lsw_pkg::line_t           rows
);

	lsw_pkg::line_t mem [lsw_pkg::MAX_WIDTH];
	lsw_pkg::line_t rdata_q;
	lsw_pkg::line_t fwd_data_q;
	logic [lsw_pkg::COL_W-1:0] fwd_col_q;
	logic fwd_vld_q;
	lsw_pkg::line_t wdata;

	// the request just ahead may have written this column on the same edge we read it
	assign rows = (fwd_vld_q && fwd_col_q == wr_col) ? fwd_data_q : rdata_q;

	always_comb begin
		for (int i = 0; i < lsw_pkg::LS_ROWS; i++) begin
			wdata[i] = (lsw_pkg::SLOT_W'(i) == wr_slot) ? wr_pix : rows[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rdata_q <= mem[rd_col];
		end
		if (ctl.wr) begin
			mem[wr_col] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (ctl.wr) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			fwd_col_q  <= wr_col;
			fwd_data_q <= wdata;
		end
	end

endmodule

@@ rtl/lsw_window.sv @@
// Window shift registers, masked row sums and the final clamp.
module lsw_window (
	input  logic                       clk,
	input  lsw_pkg::win_ctl_t          ctl,
	input  lsw_pkg::pix_t              pix,
	input  logic [lsw_pkg::SLOT_W-1:0] slot,
	input  lsw_pkg::line_t             lines,
	input  logic [lsw_pkg::MASK_W-1:0] n,
	output logic [7:0]                 sharp
);

	// win_q[b][j]: b rows back from the newest row, j columns back from the newest column
	lsw_pkg::wcol_t win_q [lsw_pkg::MAX_MASK];
	lsw_pkg::wcol_t new_col;
	logic [lsw_pkg::RSUM_W-1:0] rsum [lsw_pkg::MAX_MASK];
	logic [lsw_pkg::RSUM_W-1:0] rsum_s3 [lsw_pkg::MAX_MASK];
	logic [lsw_pkg::MASK_W-1:0] ci;
	lsw_pkg::pix_t ctr_s3;
	logic [lsw_pkg::SQ_W-1:0] sq_s3;
	logic [lsw_pkg::TOT_W-1:0] total;
	logic [lsw_pkg::TOT_W-1:0] weighted;
	logic signed [lsw_pkg::TOT_W:0] diff;
	logic [lsw_pkg::SLOT_W:0] idx;

	always_comb begin
		new_col[0] = pix;
		for (int b = 1; b < lsw_pkg::MAX_MASK; b++) begin
			idx = {1'b0, slot} + (lsw_pkg::SLOT_W+1)'(lsw_pkg::LS_ROWS - b);
			if (idx >= (lsw_pkg::SLOT_W+1)'(lsw_pkg::LS_ROWS)) begin
				idx = idx - (lsw_pkg::SLOT_W+1)'(lsw_pkg::LS_ROWS);
			end
			new_col[b] = lines[idx[lsw_pkg::SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			for (int b = 0; b < lsw_pkg::MAX_MASK; b++) begin
				win_q[b][0] <= new_col[b];
				for (int j = 1; j < lsw_pkg::MAX_MASK; j++) begin
					win_q[b][j] <= win_q[b][j-1];
				end
			end
		end
	end

	always_comb begin
		ci = n - 1'b1 - (n >> 1);
		for (int b = 0; b < lsw_pkg::MAX_MASK; b++) begin
			rsum[b] = '0;
			for (int j = 0; j < lsw_pkg::MAX_MASK; j++) begin
				if (lsw_pkg::MASK_W'(b) < n && lsw_pkg::MASK_W'(j) < n) begin
					rsum[b] = rsum[b] + lsw_pkg::RSUM_W'(win_q[b][j]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sum) begin
			rsum_s3 <= rsum;
			ctr_s3  <= win_q[ci[lsw_pkg::MASK_W-1:0]][ci];
			sq_s3   <= lsw_pkg::SQ_W'(n) * lsw_pkg::SQ_W'(n);
		end
	end

	// center*(n*n-1) - others == center*n*n - total
	always_comb begin
		total = '0;
		for (int b = 0; b < lsw_pkg::MAX_MASK; b++) begin
			total = total + lsw_pkg::TOT_W'(rsum_s3[b]);
		end
		weighted = lsw_pkg::TOT_W'(ctr_s3) * lsw_pkg::TOT_W'(sq_s3);
		diff = $signed({1'b0, weighted}) - $signed({1'b0, total});
		if (diff < 0) begin
			sharp = '0;
		end else if (diff > 255) begin
			sharp = 8'hFF;
		end else begin
			sharp = diff[7:0];
		end
	end

endmodule
